// ----- rtl/crrpa_pkg.sv -----
// ----------------------------------------------------------------------------
// crrpa_pkg
// shared constants, codes and types of the credit round-robin port arbiter
// ----------------------------------------------------------------------------
package crrpa_pkg;

  localparam int PORTS       = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_BITS    = 16;

  localparam int PORT_W  = $clog2(PORTS);
  localparam int NP_W    = $clog2(PORTS + 1);
  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = PORT_W + HEAD_W;
  localparam int MEM_DEPTH = PORTS * QUEUE_DEPTH;
  localparam int ENTRY_W = TAG_BITS + 2;

  localparam int CRED_W  = 4;
  localparam int BURST_W = 8;
  localparam int ACT_W   = 3;
  localparam int CFG_W   = 8;
  localparam int CFGI_W  = 2;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_CREDITS = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_BURST   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_ACTIVE  = 2'd2;

  // operation codes
  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // reset values of the configuration registers
  localparam logic [CRED_W-1:0]  CREDITS_RESET = 4'd1;
  localparam logic [BURST_W-1:0] BURST_RESET   = 8'd4;
  localparam logic [ACT_W-1:0]   ACTIVE_RESET  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  typedef struct packed {
    logic                accepted;
    logic                credit_left;
    logic                issued;
    logic [TAG_BITS-1:0] tag;
    logic [PORT_W-1:0]   port;
    logic                is_response;
    logic [BURST_W-1:0]  latency;
  } result_t;

endpackage

// ----- rtl/credit_round_robin_port_arbiter.sv -----
// ----------------------------------------------------------------------------
// credit_round_robin_port_arbiter
// per-port command queues with credits, drained by a round-robin arbiter
// ----------------------------------------------------------------------------
// Each command transaction is either an enqueue (op 0), which stores tag and
// read/data flags in the queue of its port and uses one credit, or a clock
// tick (op 1), which counts down the busy counter or, when that is zero,
// tries to issue the head of the queue under the grant pointer. Every command
// produces exactly one response transaction. Only an arbitrating tick
// passes through the issue state, as the queue head comes out of the
// synchronous queue memory in the cycle after its address is presented.
// Responses sit in an output register backed by one skid entry, so one
// further command is taken while a response waits on rsp_stall.
// Configuration writes (cfg_we/cfg_index/cfg_data) belong in idle periods;
// writing the credit register reloads every port's credits as the new limit
// (capped at the queue depth) minus the entries already queued. No clearing
// pass is needed after reset: queue entries are only read once written.
module credit_round_robin_port_arbiter
  import crrpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [CFGI_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // command channel
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic                op,
  input  logic [PORT_W-1:0]   port,
  input  logic [TAG_BITS-1:0] tag,
  input  logic                is_read,
  input  logic                is_data,
  input  logic                dest_ready,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                accepted,
  output logic                credit_left,
  output logic                issued,
  output logic [TAG_BITS-1:0] issued_tag,
  output logic [PORT_W-1:0]   issued_port,
  output logic                issued_is_response,
  output logic [BURST_W-1:0]  issued_latency
);

  // configuration registers; the credit limit only acts at its write
  logic [BURST_W-1:0] burst_cycles;
  logic [ACT_W-1:0]   active_ports;

  // per-port control state
  logic [HEAD_W-1:0] head [PORTS];
  logic [CNT_W-1:0]  count [PORTS];
  logic [CNT_W-1:0]  credit [PORTS];
  logic [HEAD_W-1:0] head_next [PORTS];
  logic [CNT_W-1:0]  count_next [PORTS];
  logic [CNT_W-1:0]  credit_next [PORTS];
  logic [PORT_W-1:0] grant_ptr;
  logic [PORT_W-1:0] grant_ptr_next;
  logic [BURST_W-1:0] busy;
  logic [BURST_W-1:0] busy_next;

  // queue memory
  logic [ENTRY_W-1:0] queue_mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // sequencing
  state_t      state;
  state_t      state_next;
  logic        cmd_acc;
  logic [PORT_W-1:0] port_q;
  logic        ready_q;

  // response path
  result_t res_now;
  logic    res_now_valid;
  result_t out_q;
  logic    out_valid;
  result_t skid_q;
  logic    skid_valid;

  // combinational helpers
  logic [NP_W-1:0]   live_n;
  logic [CNT_W-1:0]  lim_new;
  logic [HEAD_W-1:0] slot_sum;
  logic [PORT_W-1:0] cred_port;
  logic              head_rd;
  logic              head_dt;
  logic              head_resp;
  logic [BURST_W-1:0] lat;
  logic [NP_W-1:0]   gm;
  logic [NP_W-1:0]   cand;
  logic              found;

  assign cmd_acc = cmd_valid && !cmd_stall;

  // active port count clamped to 1..PORTS
  always_comb begin
    if (active_ports == '0) begin
      live_n = NP_W'(1);
    end else if (active_ports > ACT_W'(PORTS)) begin
      live_n = NP_W'(PORTS);
    end else begin
      live_n = NP_W'(active_ports);
    end
  end

  // new credit limit on a credit register write
  always_comb begin
    if (cfg_data[CRED_W-1:0] > CRED_W'(QUEUE_DEPTH)) begin
      lim_new = CNT_W'(QUEUE_DEPTH);
    end else begin
      lim_new = CNT_W'(cfg_data[CRED_W-1:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_acc && op == OP_TICK && busy == '0) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    case (state)
      ST_IDLE:  cmd_stall = skid_valid;
      ST_ISSUE: cmd_stall = 1'b1;
      default:  cmd_stall = 1'b1;
    endcase
  end

  // queue head decode
  assign head_rd   = mem_rdata[TAG_BITS];
  assign head_dt   = mem_rdata[TAG_BITS+1];
  assign head_resp = head_rd && head_dt;

  always_comb begin
    if (!head_dt) begin
      lat = BURST_W'(1);
    end else if (burst_cycles == '0) begin
      lat = BURST_W'(1);
    end else begin
      lat = burst_cycles;
    end
  end

  // read-modify-write of the control state
  always_comb begin
    head_next      = head;
    count_next     = count;
    credit_next    = credit;
    grant_ptr_next = grant_ptr;
    busy_next      = busy;
    mem_we         = 1'b0;
    slot_sum       = head[port] + count[port][HEAD_W-1:0];
    mem_waddr      = {port, slot_sum};
    mem_wdata      = {is_data, is_read, tag};
    res_now        = '0;
    res_now_valid  = 1'b0;
    cred_port      = port;
    gm             = NP_W'(grant_ptr);
    cand           = '0;
    found          = 1'b0;

    if (state == ST_IDLE && cmd_acc) begin
      if (op == OP_ENQ) begin
        res_now_valid = 1'b1;
        if ({1'b0, port} < live_n && credit[port] != '0 &&
            count[port] < CNT_W'(QUEUE_DEPTH)) begin
          mem_we            = 1'b1;
          count_next[port]  = count[port] + CNT_W'(1);
          credit_next[port] = credit[port] - CNT_W'(1);
          res_now.accepted  = 1'b1;
        end
      end else if (busy != '0) begin
        // busy tick only counts down
        res_now_valid = 1'b1;
        busy_next     = busy - BURST_W'(1);
      end
    end else if (state == ST_ISSUE) begin
      res_now_valid = 1'b1;
      cred_port     = port_q;
      if ({1'b0, grant_ptr} < live_n && count[grant_ptr] != '0 &&
          (head_resp || ready_q)) begin
        head_next[grant_ptr]   = head[grant_ptr] + HEAD_W'(1);
        count_next[grant_ptr]  = count[grant_ptr] - CNT_W'(1);
        credit_next[grant_ptr] = credit[grant_ptr] + CNT_W'(1);
        busy_next              = lat - BURST_W'(1);
        res_now.issued         = 1'b1;
        res_now.tag            = mem_rdata[TAG_BITS-1:0];
        res_now.port           = grant_ptr;
        res_now.is_response    = head_resp;
        res_now.latency        = lat;
      end
      // pointer reduced into the active range, then round-robin search
      for (int k = 0; k < PORTS - 1; k++) begin
        if (gm >= live_n) begin
          gm = gm - live_n;
        end
      end
      for (int i = 1; i <= PORTS; i++) begin
        if (!found && NP_W'(i) <= live_n) begin
          cand = gm + NP_W'(i);
          if (cand >= live_n) begin
            cand = cand - live_n;
          end
          if (count_next[cand[PORT_W-1:0]] != '0) begin
            grant_ptr_next = cand[PORT_W-1:0];
            found          = 1'b1;
          end
        end
      end
    end

    res_now.credit_left = ({1'b0, cred_port} < live_n) && (credit_next[cred_port] != '0);

    // credit register write reloads every port from the new limit
    if (cfg_we && cfg_index == CFG_CREDITS) begin
      for (int p = 0; p < PORTS; p++) begin
        credit_next[p] = (count[p] >= lim_new) ? '0 : lim_new - count[p];
      end
    end
  end

  // queue memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_acc) begin
      mem_rdata <= queue_mem[{grant_ptr, head[grant_ptr]}];
    end
  end

  // transaction fields held for the issue cycle
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      port_q  <= port;
      ready_q <= dest_ready;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      burst_cycles     <= BURST_RESET;
      active_ports     <= ACTIVE_RESET;
      grant_ptr        <= '0;
      busy             <= '0;
      for (int p = 0; p < PORTS; p++) begin
        head[p]   <= '0;
        count[p]  <= '0;
        credit[p] <= (CREDITS_RESET > CRED_W'(QUEUE_DEPTH)) ?
                     CNT_W'(QUEUE_DEPTH) : CNT_W'(CREDITS_RESET);
      end
    end else begin
      state     <= state_next;
      grant_ptr <= grant_ptr_next;
      busy      <= busy_next;
      head      <= head_next;
      count     <= count_next;
      credit    <= credit_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BURST:  burst_cycles <= cfg_data[BURST_W-1:0];
          CFG_ACTIVE: active_ports <= cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !rsp_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_now_valid;
      end else begin
        out_valid  <= res_now_valid;
      end
    end else if (res_now_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !rsp_stall) begin
      if (skid_valid) begin
        out_q <= skid_q;
        if (res_now_valid) begin
          skid_q <= res_now;
        end
      end else if (res_now_valid) begin
        out_q <= res_now;
      end
    end else if (res_now_valid) begin
      skid_q <= res_now;
    end
  end

  assign rsp_valid          = out_valid;
  assign accepted           = out_q.accepted;
  assign credit_left        = out_q.credit_left;
  assign issued             = out_q.issued;
  assign issued_tag         = out_q.tag;
  assign issued_port        = out_q.port;
  assign issued_is_response = out_q.is_response;
  assign issued_latency     = out_q.latency;

  // the skid entry only fills behind a held response
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without a held response");

  // an idle tick goes through the issue cycle
  a_tick_to_issue: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && op == OP_TICK && busy == '0) |=> state == ST_ISSUE)
    else $error("arbitrating tick did not enter the issue cycle");

  // a busy tick counts down by one
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && op == OP_TICK && busy != '0) |=> busy == $past(busy) - BURST_W'(1))
    else $error("busy counter did not count down");

  // an issued response always carries a nonzero latency
  a_issue_latency: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.issued) |-> out_q.latency != '0)
    else $error("issued transaction with zero latency");

endmodule
